// ===== rtl/core/brs_pkg.sv =====
// shared types, constants and helpers of the boolean rule search block
`default_nettype none

package brs_pkg;

    localparam int ROWS      = 256;
    localparam int ROW_AW    = 8;
    localparam int RES_W     = 16;
    localparam int FEAT_W    = 16;
    localparam int LIT_W     = 5;
    localparam int NLIT      = 32;
    localparam int SUM_W     = 25;
    localparam int CNT_W     = 9;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 47;
    localparam int PROD_W    = 56;
    localparam int TOP_DEPTH = 128;
    localparam int KEEP_W    = 8;
    localparam int TOT_W     = 13;
    localparam int LST_AW    = 9;

    // configuration register indexes
    localparam logic CFG_KEEP_PAIRS   = 1'b0;
    localparam logic CFG_KEEP_TRIPLES = 1'b1;

    typedef struct packed {
        logic              unas;
        logic [RES_W-1:0]  resid;
        logic [FEAT_W-1:0] feat;
    } row_t;

    typedef struct packed {
        logic [1:0]       nlit;
        logic [LIT_W-1:0] lit0;
        logic [LIT_W-1:0] lit1;
        logic [LIT_W-1:0] lit2;
        logic             op0;
        logic             op1;
    } cand_t;

    typedef struct packed {
        cand_t            rule;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } ent_t;

    function automatic logic lit_hit(input logic [FEAT_W-1:0] feat, input logic [LIT_W-1:0] lit);
        return feat[lit[LIT_W-1:1]] == lit[0];
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] n;
        n = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
        return n[MAG_W-1:0];
    endfunction

    function automatic logic [KEEP_W-1:0] clip_keep(input logic [KEEP_W-1:0] k);
        return (k > KEEP_W'(TOP_DEPTH)) ? KEEP_W'(TOP_DEPTH) : k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brs_tally.sv =====
// row store and sweep unit: sums residuals and counts rows covered by one rule
`default_nettype none

module brs_tally (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [brs_pkg::ROW_AW-1:0]  wr_addr,
    input  wire brs_pkg::row_t               wr_row,
    input  wire logic                        start,
    input  wire brs_pkg::cand_t              cand,
    input  wire logic                        only_unas,
    input  wire logic [brs_pkg::CNT_W-1:0]   nrows,
    output logic                             done,
    output logic [brs_pkg::SUM_W-1:0]        sum,
    output logic [brs_pkg::CNT_W-1:0]        cnt
);

    brs_pkg::row_t row_mem [brs_pkg::ROWS];
    brs_pkg::row_t rd_reg;

    logic                       run_reg;
    logic [brs_pkg::ROW_AW-1:0] addr_reg;
    logic                       vld_reg;
    logic                       last_reg;
    brs_pkg::cand_t             cand_reg;
    logic                       unas_reg;
    logic [brs_pkg::SUM_W-1:0]  sum_reg;
    logic [brs_pkg::CNT_W-1:0]  cnt_reg;
    logic                       done_reg;

    logic last_now;
    logic h0, h1, h2, hp, cov, hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        rd_reg <= row_mem[addr_reg];
    end

    assign last_now = ({1'b0, addr_reg} == (nrows - brs_pkg::CNT_W'(1)));

    always_comb
    begin
        h0 = brs_pkg::lit_hit(rd_reg.feat, cand_reg.lit0);
        h1 = brs_pkg::lit_hit(rd_reg.feat, cand_reg.lit1);
        h2 = brs_pkg::lit_hit(rd_reg.feat, cand_reg.lit2);
        hp = cand_reg.op0 ? (h0 | h1) : (h0 & h1);
        unique case (cand_reg.nlit)
            2'd2:    cov = hp;
            2'd3:    cov = cand_reg.op1 ? (hp | h2) : (hp & h2);
            default: cov = h0;
        endcase
        hit = cov && (!unas_reg || rd_reg.unas);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            addr_reg <= '0;
            vld_reg  <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            cand_reg <= '0;
            unas_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                addr_reg <= '0;
                vld_reg  <= 1'b0;
                last_reg <= 1'b0;
                sum_reg  <= '0;
                cnt_reg  <= '0;
                cand_reg <= cand;
                unas_reg <= only_unas;
            end
            else
            begin
                // read data is registered and lands in the cycle after the address
                vld_reg  <= run_reg;
                last_reg <= run_reg && last_now;
                if (run_reg)
                begin
                    addr_reg <= addr_reg + brs_pkg::ROW_AW'(1);
                    if (last_now)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                if (vld_reg)
                begin
                    if (hit)
                    begin
                        sum_reg <= sum_reg + {{(brs_pkg::SUM_W-brs_pkg::RES_W){rd_reg.resid[brs_pkg::RES_W-1]}},
                                              rd_reg.resid};
                        cnt_reg <= cnt_reg + brs_pkg::CNT_W'(1);
                    end
                    if (last_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;
    assign cnt  = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/brs_cmp.sv =====
// exact metric compare sa^2*cb > sb^2*ca with one squarer and one multiplier
`default_nettype none

module brs_cmp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [brs_pkg::SUM_W-1:0]  sa,
    input  wire logic [brs_pkg::CNT_W-1:0]  ca,
    input  wire logic [brs_pkg::SUM_W-1:0]  sb,
    input  wire logic [brs_pkg::CNT_W-1:0]  cb,
    output logic                            done,
    output logic                            gt,
    output logic [brs_pkg::SQ_W-1:0]        sq_a
);

    typedef enum logic [1:0] {IDLE, MUL_A, MUL_B, CMP} state_t;

    state_t                        state_reg;
    logic [brs_pkg::MAG_W-1:0]     mb_reg;
    logic [brs_pkg::CNT_W-1:0]     ca_reg;
    logic [brs_pkg::CNT_W-1:0]     cb_reg;
    logic [brs_pkg::SQ_W-1:0]      sq_reg;
    logic [brs_pkg::SQ_W-1:0]      sqa_reg;
    logic [brs_pkg::PROD_W-1:0]    pa_reg;
    logic [brs_pkg::PROD_W-1:0]    pb_reg;
    logic                          done_reg;
    logic                          gt_reg;

    logic [brs_pkg::MAG_W-1:0]     sq_in;
    logic [2*brs_pkg::MAG_W-1:0]   sq_full;
    logic [brs_pkg::CNT_W-1:0]     mul_b;
    logic [brs_pkg::PROD_W-1:0]    prod;

    assign sq_in   = (state_reg == IDLE) ? brs_pkg::mag(sa) : mb_reg;
    assign sq_full = sq_in * sq_in;
    assign mul_b   = (state_reg == MUL_A) ? cb_reg : ca_reg;
    assign prod    = brs_pkg::PROD_W'(sq_reg) * brs_pkg::PROD_W'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
            gt_reg    <= 1'b0;
            mb_reg    <= '0;
            ca_reg    <= '0;
            cb_reg    <= '0;
            sq_reg    <= '0;
            sqa_reg   <= '0;
            pa_reg    <= '0;
            pb_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        sq_reg    <= sq_full[brs_pkg::SQ_W-1:0];
                        mb_reg    <= brs_pkg::mag(sb);
                        ca_reg    <= ca;
                        cb_reg    <= cb;
                        state_reg <= MUL_A;
                    end
                end
                MUL_A:
                begin
                    pa_reg    <= prod;
                    sqa_reg   <= sq_reg;
                    sq_reg    <= sq_full[brs_pkg::SQ_W-1:0];
                    state_reg <= MUL_B;
                end
                MUL_B:
                begin
                    pb_reg    <= prod;
                    state_reg <= CMP;
                end
                CMP:
                begin
                    gt_reg    <= pa_reg > pb_reg;
                    done_reg  <= 1'b1;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign gt   = gt_reg;
    assign sq_a = sqa_reg;

endmodule

`default_nettype wire

// ===== rtl/core/brs_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module brs_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [brs_pkg::SQ_W-1:0]  dend,
    input  wire logic [brs_pkg::CNT_W-1:0] dsor,
    output logic                           done,
    output logic [brs_pkg::SQ_W-1:0]       quot
);

    localparam int STEP_W = $clog2(brs_pkg::SQ_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [brs_pkg::SQ_W-1:0]     q_reg;
    logic [brs_pkg::CNT_W-1:0]    rem_reg;
    logic [brs_pkg::CNT_W-1:0]    d_reg;

    logic [brs_pkg::CNT_W:0]      trial;
    logic                         fits;
    logic [brs_pkg::CNT_W:0]      diff;

    assign trial = {rem_reg, q_reg[brs_pkg::SQ_W-1]};
    assign fits  = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(brs_pkg::SQ_W - 1);
                q_reg    <= dend;
                rem_reg  <= '0;
                d_reg    <= dsor;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[brs_pkg::SQ_W-2:0], fits};
                rem_reg <= fits ? diff[brs_pkg::CNT_W-1:0] : trial[brs_pkg::CNT_W-1:0];
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/boolean_rule_search_topk.sv =====
// Boolean rule search over up to 256 loaded rows with two top-k cuts (default 100 each).
// Rows load at one beat per cycle; the beat with tlast starts the search and s_tready
// stays low until the result is handed to the output register. Every candidate is
// scored by the tally unit, which sweeps the row memory one row per cycle. The search
// scores 32 literals, up to 960 pairs, up to 2*28*keep_pairs triples, then up to
// 32+keep_pairs+keep_triples rules again over the unassigned rows; each offered
// candidate also passes a sorted insertion into its list. The mean and score of the
// result come from the serial divider. keep_pairs and keep_triples (index 0 and 1
// on the cfg port) above 128 act as 128, 0 keeps nothing.
`default_nettype none

module boolean_rule_search_topk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // feature_bits[15:0], residual[31:16], row_unassigned[32], zero pad
    input  wire logic        s_tlast,   // last_row
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // rule_found[0], literal_count[2:1], first_literal[7:3],
                                        // second_literal[12:8], third_literal[17:13], inner_op[18],
                                        // outer_op[19], covered_rows[28:20], mean_residual[44:29],
                                        // score[91:45], zero pad
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_data
);

    typedef enum logic [5:0] {
        LOAD, LIT_GO, LIT_WAIT, PAIR_INIT, PAIR_CHECK, GEN_GO, GEN_WAIT, OFFER,
        SCAN, SCAN_RD, SCAN_CMP, INS_PREP, SHIFT, SHIFT_WR, NEXT, PAIR_FIN,
        TRI_INIT, TRI_LOAD, TRI_LD2, TRI_CHECK, TRI_FIN, FIN_CHECK, FIN_RD, FIN_GO,
        FIN_WAIT, FIN_EVAL, FIN_CMP, FIN_ADV, OUT_PREP, OUT_SQ, OUT_SQW, OUT_MEAN,
        OUT_MEANW, OUT_SCORE, OUT_SCOREW, OUT_WAIT
    } state_t;

    state_t                          state_reg;
    logic [brs_pkg::CNT_W-1:0]       row_cnt_reg;
    logic [brs_pkg::KEEP_W-1:0]      keep_pairs_reg;
    logic [brs_pkg::KEEP_W-1:0]      keep_triples_reg;
    logic [brs_pkg::NLIT-1:0]        nz_reg;
    logic                            lsel_reg;
    logic [brs_pkg::KEEP_W-1:0]      k_reg;
    logic [brs_pkg::KEEP_W-1:0]      count_reg;
    logic [brs_pkg::KEEP_W-1:0]      gcount_reg;
    logic [brs_pkg::TOT_W-1:0]       total_reg;
    logic [brs_pkg::KEEP_W-1:0]      i_reg;
    logic [brs_pkg::LIT_W-1:0]       j_reg;
    logic                            op_reg;
    brs_pkg::cand_t                  cand_reg;
    logic [brs_pkg::SUM_W-1:0]       c_sum_reg;
    logic [brs_pkg::CNT_W-1:0]       c_cnt_reg;
    logic [brs_pkg::KEEP_W-1:0]      pos_reg;
    logic [brs_pkg::KEEP_W-1:0]      sh_reg;
    logic [brs_pkg::KEEP_W-1:0]      p_count_reg;
    logic                            p_gen_reg;
    logic [brs_pkg::KEEP_W-1:0]      t_count_reg;
    logic                            t_gen_reg;
    logic [1:0]                      fphase_reg;
    logic                            found_reg;
    brs_pkg::cand_t                  best_cand_reg;
    logic [brs_pkg::SUM_W-1:0]       best_sum_reg;
    logic [brs_pkg::CNT_W-1:0]       best_cnt_reg;
    logic [brs_pkg::SQ_W-1:0]        sq_reg;
    logic [brs_pkg::RES_W-1:0]       mean_reg;
    logic [brs_pkg::SQ_W-1:0]        score_reg;
    logic                            m_valid_reg;
    logic [95:0]                     m_data_reg;

    brs_pkg::ent_t                   lst_mem [2**brs_pkg::LST_AW];
    brs_pkg::ent_t                   rd_reg;
    logic [brs_pkg::LST_AW-1:0]      lst_ra;
    logic                            lst_we;
    logic [brs_pkg::LST_AW-1:0]      lst_wa;
    brs_pkg::ent_t                   lst_wd;

    logic                            s_acc;
    brs_pkg::row_t                   in_row;
    logic                            tally_start;
    brs_pkg::cand_t                  tally_cand;
    brs_pkg::cand_t                  cand_cur;
    logic                            tally_done;
    logic [brs_pkg::SUM_W-1:0]       tally_sum;
    logic [brs_pkg::CNT_W-1:0]       tally_cnt;
    logic                            cmp_start;
    logic [brs_pkg::SUM_W-1:0]       cmp_sa;
    logic [brs_pkg::CNT_W-1:0]       cmp_ca;
    logic [brs_pkg::SUM_W-1:0]       cmp_sb;
    logic [brs_pkg::CNT_W-1:0]       cmp_cb;
    logic                            cmp_done;
    logic                            cmp_gt;
    logic [brs_pkg::SQ_W-1:0]        cmp_sq;
    logic                            div_start;
    logic [brs_pkg::SQ_W-1:0]        div_dend;
    logic                            div_done;
    logic [brs_pkg::SQ_W-1:0]        div_quot;
    brs_pkg::ent_t                   cur_ent;
    logic                            pair_ok;
    logic                            tri_ok;
    logic                            fin_need_cmp;
    logic [brs_pkg::KEEP_W-1:0]      adv_i;
    logic [brs_pkg::LIT_W-1:0]       adv_j;
    state_t                          adv_st;
    logic [brs_pkg::RES_W:0]         q_mean;
    logic [brs_pkg::RES_W:0]         mean_s;
    logic [95:0]                     out_word;

    assign s_tready = (state_reg == LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign in_row   = '{unas: s_tdata[32], resid: s_tdata[31:16], feat: s_tdata[15:0]};

    // current candidate with the op under test in its slot
    always_comb
    begin
        cand_cur = cand_reg;
        if (lsel_reg)
        begin
            cand_cur.op1 = op_reg;
        end
        else
        begin
            cand_cur.op0 = op_reg;
        end
    end

    assign cur_ent = '{rule: cand_cur, sum: c_sum_reg, cnt: c_cnt_reg};

    always_comb
    begin
        tally_cand = cand_reg;
        if (state_reg == LIT_GO)
        begin
            tally_cand = '{nlit: 2'd1, lit0: i_reg[brs_pkg::LIT_W-1:0], lit1: '0, lit2: '0,
                           op0: 1'b0, op1: 1'b0};
        end
        else if (state_reg == GEN_GO)
        begin
            tally_cand = cand_cur;
        end
    end

    assign tally_start = (state_reg == LIT_GO) || (state_reg == GEN_GO) || (state_reg == FIN_GO);

    brs_tally u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (s_acc && (row_cnt_reg < brs_pkg::CNT_W'(brs_pkg::ROWS))),
        .wr_addr   (row_cnt_reg[brs_pkg::ROW_AW-1:0]),
        .wr_row    (in_row),
        .start     (tally_start),
        .cand      (tally_cand),
        .only_unas (state_reg == FIN_GO),
        .nrows     (row_cnt_reg),
        .done      (tally_done),
        .sum       (tally_sum),
        .cnt       (tally_cnt)
    );

    assign fin_need_cmp = (c_cnt_reg != '0) && found_reg;
    assign cmp_start = (state_reg == SCAN_RD) || (state_reg == OUT_SQ) ||
                       ((state_reg == FIN_EVAL) && fin_need_cmp);

    always_comb
    begin
        cmp_sa = c_sum_reg;
        cmp_ca = c_cnt_reg;
        cmp_sb = best_sum_reg;
        cmp_cb = best_cnt_reg;
        if (state_reg == SCAN_RD)
        begin
            cmp_sb = rd_reg.sum;
            cmp_cb = rd_reg.cnt;
        end
        else if (state_reg == OUT_SQ)
        begin
            cmp_sa = best_sum_reg;
            cmp_ca = brs_pkg::CNT_W'(1);
            cmp_sb = '0;
            cmp_cb = brs_pkg::CNT_W'(1);
        end
    end

    brs_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmp_start),
        .sa    (cmp_sa),
        .ca    (cmp_ca),
        .sb    (cmp_sb),
        .cb    (cmp_cb),
        .done  (cmp_done),
        .gt    (cmp_gt),
        .sq_a  (cmp_sq)
    );

    assign div_start = (state_reg == OUT_MEAN) || (state_reg == OUT_SCORE);
    assign div_dend  = (state_reg == OUT_MEAN) ?
                       brs_pkg::SQ_W'(brs_pkg::mag(best_sum_reg)) : sq_reg;

    brs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dend  (div_dend),
        .dsor  (best_cnt_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_mean = div_quot[brs_pkg::RES_W:0];
    assign mean_s = best_sum_reg[brs_pkg::SUM_W-1] ? (~q_mean + (brs_pkg::RES_W+1)'(1)) : q_mean;

    // list memory: {list, generation-order region, index}
    always_comb
    begin
        unique case (state_reg)
            SCAN:      lst_ra = {lsel_reg, 1'b0, pos_reg[6:0]};
            SHIFT:     lst_ra = {lsel_reg, 1'b0, 7'(sh_reg - brs_pkg::KEEP_W'(1))};
            TRI_LOAD:  lst_ra = {1'b0, p_gen_reg, i_reg[6:0]};
            FIN_CHECK: lst_ra = (fphase_reg == 2'd2) ? {1'b1, t_gen_reg, i_reg[6:0]}
                                                     : {1'b0, p_gen_reg, i_reg[6:0]};
            default:   lst_ra = '0;
        endcase
    end

    always_comb
    begin
        lst_we = 1'b0;
        lst_wa = '0;
        lst_wd = cur_ent;
        unique case (state_reg)
            OFFER:
            begin
                lst_we = (k_reg != '0) && (gcount_reg < k_reg);
                lst_wa = {lsel_reg, 1'b1, gcount_reg[6:0]};
            end
            SHIFT:
            begin
                lst_we = !(sh_reg > pos_reg);
                lst_wa = {lsel_reg, 1'b0, pos_reg[6:0]};
            end
            SHIFT_WR:
            begin
                lst_we = 1'b1;
                lst_wa = {lsel_reg, 1'b0, sh_reg[6:0]};
                lst_wd = rd_reg;
            end
            default:
            begin
                lst_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lst_we)
        begin
            lst_mem[lst_wa] <= lst_wd;
        end
        rd_reg <= lst_mem[lst_ra];
    end

    assign pair_ok = nz_reg[i_reg[brs_pkg::LIT_W-1:0]] && nz_reg[j_reg] &&
                     (i_reg[brs_pkg::LIT_W-1:1] != j_reg[brs_pkg::LIT_W-1:1]);
    assign tri_ok  = nz_reg[j_reg] &&
                     (j_reg[brs_pkg::LIT_W-1:1] != cand_reg.lit0[brs_pkg::LIT_W-1:1]) &&
                     (j_reg[brs_pkg::LIT_W-1:1] != cand_reg.lit1[brs_pkg::LIT_W-1:1]);

    // step to the next pair or triple candidate
    always_comb
    begin
        adv_i  = i_reg;
        adv_j  = j_reg + brs_pkg::LIT_W'(1);
        adv_st = lsel_reg ? TRI_CHECK : PAIR_CHECK;
        if (j_reg == brs_pkg::LIT_W'(brs_pkg::NLIT - 1))
        begin
            adv_i = i_reg + brs_pkg::KEEP_W'(1);
            if (!lsel_reg)
            begin
                adv_j = i_reg[brs_pkg::LIT_W-1:0] + brs_pkg::LIT_W'(2);
                if (i_reg == brs_pkg::KEEP_W'(brs_pkg::NLIT - 2))
                begin
                    adv_st = PAIR_FIN;
                end
            end
            else
            begin
                adv_j  = '0;
                adv_st = (adv_i == p_count_reg) ? TRI_FIN : TRI_LOAD;
            end
        end
    end

    always_comb
    begin
        out_word = '0;
        if (found_reg)
        begin
            out_word[0]     = 1'b1;
            out_word[2:1]   = best_cand_reg.nlit;
            out_word[7:3]   = best_cand_reg.lit0;
            out_word[12:8]  = best_cand_reg.lit1;
            out_word[17:13] = best_cand_reg.lit2;
            out_word[18]    = best_cand_reg.op0;
            out_word[19]    = best_cand_reg.op1;
            out_word[28:20] = best_cnt_reg;
            out_word[44:29] = mean_reg;
            out_word[91:45] = score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= LOAD;
            row_cnt_reg      <= '0;
            keep_pairs_reg   <= brs_pkg::KEEP_W'(100);
            keep_triples_reg <= brs_pkg::KEEP_W'(100);
            nz_reg           <= '0;
            lsel_reg         <= 1'b0;
            k_reg            <= '0;
            count_reg        <= '0;
            gcount_reg       <= '0;
            total_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            op_reg           <= 1'b0;
            cand_reg         <= '0;
            c_sum_reg        <= '0;
            c_cnt_reg        <= '0;
            pos_reg          <= '0;
            sh_reg           <= '0;
            p_count_reg      <= '0;
            p_gen_reg        <= 1'b0;
            t_count_reg      <= '0;
            t_gen_reg        <= 1'b0;
            fphase_reg       <= '0;
            found_reg        <= 1'b0;
            best_cand_reg    <= '0;
            best_sum_reg     <= '0;
            best_cnt_reg     <= '0;
            sq_reg           <= '0;
            mean_reg         <= '0;
            score_reg        <= '0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    brs_pkg::CFG_KEEP_PAIRS:   keep_pairs_reg   <= cfg_data;
                    brs_pkg::CFG_KEEP_TRIPLES: keep_triples_reg <= cfg_data;
                    default:                   keep_pairs_reg   <= keep_pairs_reg;
                endcase
            end

            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                LOAD:
                begin
                    if (s_acc)
                    begin
                        if (row_cnt_reg < brs_pkg::CNT_W'(brs_pkg::ROWS))
                        begin
                            row_cnt_reg <= row_cnt_reg + brs_pkg::CNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            i_reg     <= '0;
                            state_reg <= LIT_GO;
                        end
                    end
                end
                LIT_GO:
                begin
                    state_reg <= LIT_WAIT;
                end
                LIT_WAIT:
                begin
                    if (tally_done)
                    begin
                        nz_reg[i_reg[brs_pkg::LIT_W-1:0]] <= (tally_cnt != '0);
                        if (i_reg == brs_pkg::KEEP_W'(brs_pkg::NLIT - 1))
                        begin
                            state_reg <= PAIR_INIT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + brs_pkg::KEEP_W'(1);
                            state_reg <= LIT_GO;
                        end
                    end
                end
                PAIR_INIT:
                begin
                    lsel_reg   <= 1'b0;
                    k_reg      <= brs_pkg::clip_keep(keep_pairs_reg);
                    count_reg  <= '0;
                    gcount_reg <= '0;
                    total_reg  <= '0;
                    i_reg      <= '0;
                    j_reg      <= brs_pkg::LIT_W'(1);
                    state_reg  <= PAIR_CHECK;
                end
                PAIR_CHECK:
                begin
                    if (pair_ok)
                    begin
                        cand_reg  <= '{nlit: 2'd2, lit0: i_reg[brs_pkg::LIT_W-1:0], lit1: j_reg,
                                       lit2: '0, op0: 1'b0, op1: 1'b0};
                        op_reg    <= 1'b0;
                        state_reg <= GEN_GO;
                    end
                    else
                    begin
                        i_reg     <= adv_i;
                        j_reg     <= adv_j;
                        state_reg <= adv_st;
                    end
                end
                GEN_GO:
                begin
                    state_reg <= GEN_WAIT;
                end
                GEN_WAIT:
                begin
                    if (tally_done)
                    begin
                        c_sum_reg <= tally_sum;
                        c_cnt_reg <= tally_cnt;
                        state_reg <= (tally_cnt != '0) ? OFFER : NEXT;
                    end
                end
                OFFER:
                begin
                    total_reg <= total_reg + brs_pkg::TOT_W'(1);
                    pos_reg   <= '0;
                    if (k_reg == '0)
                    begin
                        state_reg <= NEXT;
                    end
                    else
                    begin
                        if (gcount_reg < k_reg)
                        begin
                            gcount_reg <= gcount_reg + brs_pkg::KEEP_W'(1);
                        end
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    state_reg <= (pos_reg < count_reg) ? SCAN_RD : INS_PREP;
                end
                SCAN_RD:
                begin
                    state_reg <= SCAN_CMP;
                end
                SCAN_CMP:
                begin
                    if (cmp_done)
                    begin
                        if (cmp_gt)
                        begin
                            state_reg <= INS_PREP;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + brs_pkg::KEEP_W'(1);
                            state_reg <= SCAN;
                        end
                    end
                end
                INS_PREP:
                begin
                    if (count_reg < k_reg)
                    begin
                        sh_reg    <= count_reg;
                        count_reg <= count_reg + brs_pkg::KEEP_W'(1);
                        state_reg <= SHIFT;
                    end
                    else if (pos_reg < count_reg)
                    begin
                        sh_reg    <= count_reg - brs_pkg::KEEP_W'(1);
                        state_reg <= SHIFT;
                    end
                    else
                    begin
                        state_reg <= NEXT;
                    end
                end
                SHIFT:
                begin
                    state_reg <= (sh_reg > pos_reg) ? SHIFT_WR : NEXT;
                end
                SHIFT_WR:
                begin
                    sh_reg    <= sh_reg - brs_pkg::KEEP_W'(1);
                    state_reg <= SHIFT;
                end
                NEXT:
                begin
                    if (!op_reg)
                    begin
                        op_reg    <= 1'b1;
                        state_reg <= GEN_GO;
                    end
                    else
                    begin
                        op_reg    <= 1'b0;
                        i_reg     <= adv_i;
                        j_reg     <= adv_j;
                        state_reg <= adv_st;
                    end
                end
                PAIR_FIN:
                begin
                    p_count_reg <= count_reg;
                    p_gen_reg   <= (total_reg <= brs_pkg::TOT_W'(k_reg));
                    state_reg   <= TRI_INIT;
                end
                TRI_INIT:
                begin
                    lsel_reg   <= 1'b1;
                    k_reg      <= brs_pkg::clip_keep(keep_triples_reg);
                    count_reg  <= '0;
                    gcount_reg <= '0;
                    total_reg  <= '0;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    state_reg  <= (p_count_reg == '0) ? TRI_FIN : TRI_LOAD;
                end
                TRI_LOAD:
                begin
                    state_reg <= TRI_LD2;
                end
                TRI_LD2:
                begin
                    cand_reg  <= '{nlit: 2'd3, lit0: rd_reg.rule.lit0, lit1: rd_reg.rule.lit1,
                                   lit2: '0, op0: rd_reg.rule.op0, op1: 1'b0};
                    j_reg     <= '0;
                    op_reg    <= 1'b0;
                    state_reg <= TRI_CHECK;
                end
                TRI_CHECK:
                begin
                    if (tri_ok)
                    begin
                        cand_reg.lit2 <= j_reg;
                        op_reg        <= 1'b0;
                        state_reg     <= GEN_GO;
                    end
                    else
                    begin
                        i_reg     <= adv_i;
                        j_reg     <= adv_j;
                        state_reg <= adv_st;
                    end
                end
                TRI_FIN:
                begin
                    t_count_reg <= count_reg;
                    t_gen_reg   <= (total_reg <= brs_pkg::TOT_W'(k_reg));
                    fphase_reg  <= '0;
                    i_reg       <= '0;
                    found_reg   <= 1'b0;
                    state_reg   <= FIN_CHECK;
                end
                FIN_CHECK:
                begin
                    priority if (fphase_reg == 2'd0)
                    begin
                        cand_reg  <= '{nlit: 2'd1, lit0: i_reg[brs_pkg::LIT_W-1:0], lit1: '0,
                                       lit2: '0, op0: 1'b0, op1: 1'b0};
                        state_reg <= FIN_GO;
                    end
                    else if (fphase_reg == 2'd1)
                    begin
                        if (i_reg == p_count_reg)
                        begin
                            fphase_reg <= 2'd2;
                            i_reg      <= '0;
                        end
                        else
                        begin
                            state_reg <= FIN_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= (i_reg == t_count_reg) ? OUT_PREP : FIN_RD;
                    end
                end
                FIN_RD:
                begin
                    cand_reg  <= rd_reg.rule;
                    state_reg <= FIN_GO;
                end
                FIN_GO:
                begin
                    state_reg <= FIN_WAIT;
                end
                FIN_WAIT:
                begin
                    if (tally_done)
                    begin
                        c_sum_reg <= tally_sum;
                        c_cnt_reg <= tally_cnt;
                        state_reg <= FIN_EVAL;
                    end
                end
                FIN_EVAL:
                begin
                    if (c_cnt_reg == '0)
                    begin
                        state_reg <= FIN_ADV;
                    end
                    else if (!found_reg)
                    begin
                        found_reg     <= 1'b1;
                        best_cand_reg <= cand_reg;
                        best_sum_reg  <= c_sum_reg;
                        best_cnt_reg  <= c_cnt_reg;
                        state_reg     <= FIN_ADV;
                    end
                    else
                    begin
                        state_reg <= FIN_CMP;
                    end
                end
                FIN_CMP:
                begin
                    if (cmp_done)
                    begin
                        if (cmp_gt)
                        begin
                            best_cand_reg <= cand_reg;
                            best_sum_reg  <= c_sum_reg;
                            best_cnt_reg  <= c_cnt_reg;
                        end
                        state_reg <= FIN_ADV;
                    end
                end
                FIN_ADV:
                begin
                    if ((fphase_reg == 2'd0) && (i_reg == brs_pkg::KEEP_W'(brs_pkg::NLIT - 1)))
                    begin
                        fphase_reg <= 2'd1;
                        i_reg      <= '0;
                    end
                    else
                    begin
                        i_reg <= i_reg + brs_pkg::KEEP_W'(1);
                    end
                    state_reg <= FIN_CHECK;
                end
                OUT_PREP:
                begin
                    state_reg <= found_reg ? OUT_SQ : OUT_WAIT;
                end
                OUT_SQ:
                begin
                    state_reg <= OUT_SQW;
                end
                OUT_SQW:
                begin
                    if (cmp_done)
                    begin
                        sq_reg    <= cmp_sq;
                        state_reg <= OUT_MEAN;
                    end
                end
                OUT_MEAN:
                begin
                    state_reg <= OUT_MEANW;
                end
                OUT_MEANW:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= mean_s[brs_pkg::RES_W-1:0];
                        state_reg <= OUT_SCORE;
                    end
                end
                OUT_SCORE:
                begin
                    state_reg <= OUT_SCOREW;
                end
                OUT_SCOREW:
                begin
                    if (div_done)
                    begin
                        score_reg <= div_quot;
                        state_reg <= OUT_WAIT;
                    end
                end
                OUT_WAIT:
                begin
                    // output register free: hand the result over and start a new data set
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= out_word;
                        row_cnt_reg <= '0;
                        state_reg   <= LOAD;
                    end
                end
                default: state_reg <= LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= brs_pkg::CNT_W'(brs_pkg::ROWS))
        else $error("row count beyond row store");
    a_list_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= k_reg)
        else $error("kept list longer than its keep count");
    a_list_write: assert property (@(posedge clk) disable iff (!rst_n)
        lst_we |-> (state_reg == OFFER || state_reg == SHIFT || state_reg == SHIFT_WR))
        else $error("list write outside insertion");
    a_tally_done: assert property (@(posedge clk) disable iff (!rst_n)
        tally_done |-> (state_reg == LIT_WAIT || state_reg == GEN_WAIT || state_reg == FIN_WAIT))
        else $error("tally finished with nobody waiting");
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == OUT_WAIT))
        else $error("result beat not from the output step");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench for the boolean rule search block
`default_nettype none

typedef struct packed {
    bit        found;
    bit [1:0]  nlit;
    bit [4:0]  lit0;
    bit [4:0]  lit1;
    bit [4:0]  lit2;
    bit        iop;
    bit        oop;
    bit [8:0]  covered;
    bit [15:0] mean;
    bit [46:0] score;
} rule_result_t;

typedef struct {
    int        nlit;
    bit [4:0]  l0;
    bit [4:0]  l1;
    bit [4:0]  l2;
    bit        o0;
    bit        o1;
    longint    sum;
    int        cnt;
    int        seq;
} rule_cand_t;

class rule_predictor;
    bit [15:0]    feat[256];
    longint       resid[256];
    bit           unas[256];
    int           rows;
    int           keep_pairs;
    int           keep_triples;
    rule_result_t expected_rules[$];
    int           errors;
    int           sets_done;
    int           rules_found;
    // working list of the current top-k cut
    rule_cand_t   ranked[$];
    rule_cand_t   arrived[$];
    int           offered;
    int           cut_k;

    function new();
        rows = 0;
        keep_pairs = 100;
        keep_triples = 100;
        errors = 0;
        sets_done = 0;
        rules_found = 0;
    endfunction

    function bit hit(int r, bit [4:0] lit);
        return feat[r][lit[4:1]] == lit[0];
    endfunction

    function bit covers(rule_cand_t c, int r);
        bit h;
        h = hit(r, c.l0);
        if (c.nlit > 1) h = c.o0 ? (h | hit(r, c.l1)) : (h & hit(r, c.l1));
        if (c.nlit > 2) h = c.o1 ? (h | hit(r, c.l2)) : (h & hit(r, c.l2));
        return h;
    endfunction

    function rule_cand_t tallied(rule_cand_t c, bit only_unas);
        c.sum = 0;
        c.cnt = 0;
        for (int r = 0; r < rows; r++)
            if (covers(c, r) && (!only_unas || unas[r])) begin
                c.sum += resid[r];
                c.cnt++;
            end
        return c;
    endfunction

    function bit better(longint sa, int ca, longint sb, int cb);
        longint unsigned ma, mb;
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        return ma * ma * longint'(cb) > mb * mb * longint'(ca);
    endfunction

    function void start_cut(int k);
        ranked.delete();
        arrived.delete();
        offered = 0;
        cut_k = k > 128 ? 128 : k;
    endfunction

    function void offer(rule_cand_t c);
        int pos;
        c.seq = offered++;
        if (cut_k == 0) return;
        arrived.push_back(c);
        pos = 0;
        while (pos < ranked.size() && !better(c.sum, c.cnt, ranked[pos].sum, ranked[pos].cnt))
            pos++;
        if (ranked.size() < cut_k) ranked.insert(pos, c);
        else if (pos < ranked.size()) begin
            ranked.insert(pos, c);
            ranked.pop_back();
        end
    endfunction

    function void offer_both(rule_cand_t c);
        for (int op = 0; op < 2; op++) begin
            if (c.nlit == 2) c.o0 = op[0];
            else c.o1 = op[0];
            c = tallied(c, 0);
            if (c.cnt > 0) offer(c);
        end
    endfunction

    function void search_rules();
        int           lit_cnt[32];
        rule_cand_t   c, best;
        rule_cand_t   pairs[$];
        rule_cand_t   triples[$];
        rule_cand_t   finalists[$];
        bit           found;
        rule_result_t e;
        longint       m;
        longint unsigned sq;
        c = '{default: 0};
        c.nlit = 1;
        for (int i = 0; i < 32; i++) begin
            c.l0 = i[4:0];
            c = tallied(c, 0);
            lit_cnt[i] = c.cnt;
        end
        start_cut(keep_pairs);
        for (int i = 0; i < 31; i++) begin
            if (lit_cnt[i] == 0) continue;
            for (int j = i + 1; j < 32; j++) begin
                if (lit_cnt[j] == 0 || (i >> 1) == (j >> 1)) continue;
                c = '{default: 0};
                c.nlit = 2;
                c.l0 = i[4:0];
                c.l1 = j[4:0];
                offer_both(c);
            end
        end
        pairs = (offered <= cut_k) ? arrived : ranked;
        start_cut(keep_triples);
        foreach (pairs[i]) begin
            for (int j = 0; j < 32; j++) begin
                if (lit_cnt[j] == 0) continue;
                if ((j >> 1) == pairs[i].l0[4:1] || (j >> 1) == pairs[i].l1[4:1]) continue;
                c = pairs[i];
                c.nlit = 3;
                c.l2 = j[4:0];
                c.o1 = 0;
                offer_both(c);
            end
        end
        triples = (offered <= cut_k) ? arrived : ranked;
        c = '{default: 0};
        c.nlit = 1;
        for (int i = 0; i < 32; i++) begin
            c.l0 = i[4:0];
            finalists.push_back(c);
        end
        foreach (pairs[i]) finalists.push_back(pairs[i]);
        foreach (triples[i]) finalists.push_back(triples[i]);
        found = 0;
        best = '{default: 0};
        foreach (finalists[i]) begin
            c = tallied(finalists[i], 1);
            if (c.cnt == 0) continue;
            if (!found || better(c.sum, c.cnt, best.sum, best.cnt)) begin
                best = c;
                found = 1;
            end
        end
        e = '0;
        if (found) begin
            m = best.sum / best.cnt;
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            sq = (best.sum < 0 ? -best.sum : best.sum);
            sq = sq * sq / best.cnt;
            if (sq > 64'h7FFF_FFFF_FFFF) sq = 64'h7FFF_FFFF_FFFF;
            e.found = 1;
            e.nlit = best.nlit[1:0];
            e.lit0 = best.l0;
            e.lit1 = best.nlit > 1 ? best.l1 : 5'd0;
            e.lit2 = best.nlit > 2 ? best.l2 : 5'd0;
            e.iop = best.nlit > 1 ? best.o0 : 1'b0;
            e.oop = best.nlit > 2 ? best.o1 : 1'b0;
            e.covered = best.cnt > 511 ? 9'd511 : best.cnt[8:0];
            e.mean = m[15:0];
            e.score = sq[46:0];
            rules_found++;
        end
        expected_rules.push_back(e);
    endfunction

    function void note_row(bit [15:0] f, bit [15:0] r, bit u, bit last);
        if (rows < 256) begin
            feat[rows] = f;
            resid[rows] = longint'($signed(r));
            unas[rows] = u;
            rows++;
        end
        if (last) begin
            search_rules();
            rows = 0;
        end
    endfunction

    function void compare(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    function void check_rule(bit [95:0] d);
        rule_result_t e;
        if (expected_rules.size() == 0) begin
            $display("%0t unexpected result beat %h", $time, d);
            errors++;
            return;
        end
        e = expected_rules.pop_front();
        sets_done++;
        compare("rule_found", e.found, d[0]);
        compare("literal_count", e.nlit, d[2:1]);
        compare("first_literal", e.lit0, d[7:3]);
        compare("second_literal", e.lit1, d[12:8]);
        compare("third_literal", e.lit2, d[17:13]);
        compare("inner_op", e.iop, d[18]);
        compare("outer_op", e.oop, d[19]);
        compare("covered_rows", e.covered, d[28:20]);
        compare("mean_residual", $signed(e.mean), $signed(d[44:29]));
        compare("score", e.score, d[91:45]);
    endfunction
endclass

module testbench;
    import brs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // feature_bits[15:0], residual[31:16], row_unassigned[32], zero pad
    logic        s_tlast;   // last_row
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // rule_found[0], literal_count[2:1], first_literal[7:3],
                            // second_literal[12:8], third_literal[17:13], inner_op[18],
                            // outer_op[19], covered_rows[28:20], mean_residual[44:29],
                            // score[91:45], zero pad
    logic        cfg_we;
    logic        cfg_addr;
    logic [7:0]  cfg_data;

    rule_predictor rules;
    bit            calm;
    int            rows_sent;
    int            cfg_writes;

    boolean_rule_search_topk dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(64'd800_000_000);
        $display("Verification failed");
        $finish;
    end

    function int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_row(bit [15:0] f, bit [15:0] r, bit u, bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {7'd0, u, r, f};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        rules.note_row(f, r, u, last);
        rows_sent++;
    endtask

    // hold the source off until every outstanding rule has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rules.expected_rules.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_keep(int kp, int kt);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_KEEP_PAIRS;
        cfg_data <= kp[7:0];
        @(posedge clk);
        cfg_addr <= CFG_KEEP_TRIPLES;
        cfg_data <= kt[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        rules.keep_pairs = kp & 8'hFF;
        rules.keep_triples = kt & 8'hFF;
        cfg_writes += 2;
    endtask

    task automatic random_set(int n);
        int          style;
        int          uprob;
        bit [15:0]   f, r;
        style = $urandom_range(0, 4);
        uprob = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            f = $urandom;
            case (style)
                1: f = f & $urandom & $urandom;
                2: f = f | $urandom | $urandom;
                3: f = f & 16'h000F;
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: r = 16'h8000;
                1: r = 16'h7FFF;
                2: r = $urandom_range(0, 64) - 32;
                default: r = $urandom;
            endcase
            send_row(f, r, $urandom_range(0, 9) < uprob, i == n - 1);
        end
    endtask

    always begin
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            m_tready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        do @(posedge clk); while (!m_tvalid);
        rules.check_rule(m_tdata);
    end

    initial begin
        rules = new();
        calm = 1'b0;
        rows_sent = 0;
        cfg_writes = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_keep(3, 3);
        // single row data set with the most negative residual
        send_row(16'h0000, 16'h8000, 1, 1);
        // no unassigned row, so no rule
        send_row(16'hFFFF, 16'h7FFF, 0, 0);
        send_row(16'h0000, 16'h0000, 0, 1);
        send_row(16'h00FF, 16'h1000, 1, 0);
        send_row(16'hFF00, 16'hF000, 1, 0);
        send_row(16'hAAAA, 16'h7FFF, 1, 0);
        send_row(16'h5555, 16'h8000, 0, 0);
        send_row(16'h0F0F, 16'h0064, 1, 0);
        send_row(16'hF0F0, 16'hFF9C, 1, 0);
        send_row(16'h1234, 16'h0007, 1, 0);
        send_row(16'h8001, 16'hFFFF, 1, 1);
        // a keep count of zero keeps nothing
        write_keep(0, 2);
        random_set(4);
        write_keep(2, 0);
        random_set(4);
        // largest keep counts, and a count above the list depth
        write_keep(128, 1);
        random_set(1);
        write_keep(1, 128);
        random_set(2);
        write_keep(255, 1);
        random_set(1);
        write_keep(1, 255);
        random_set(2);
        // more rows than the store holds
        write_keep(1, 1);
        random_set(260);

        while (rows_sent < 1550) begin
            case ($urandom_range(0, 5))
                0: write_keep($urandom_range(0, 12), $urandom_range(0, 12));
                default: write_keep($urandom_range(1, 6), $urandom_range(1, 6));
            endcase
            repeat ($urandom_range(3, 6)) begin
                calm = ($urandom_range(0, 3) == 0);
                random_set($urandom_range(0, 9) == 0 ? $urandom_range(31, 64)
                                                      : $urandom_range(1, 30));
            end
        end
        calm = 1'b0;
        drain();

        $display("%0d rows in %0d data sets, %0d with a rule, %0d register writes",
                 rows_sent, rules.sets_done, rules.rules_found, cfg_writes);
        if (rules.errors == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== boolean_rule_search_topk.f =====
rtl/core/brs_pkg.sv
rtl/core/brs_tally.sv
rtl/core/brs_cmp.sv
rtl/core/brs_div.sv
rtl/core/boolean_rule_search_topk.sv
bench/testbench.sv
